// ----- rtl/trf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_pkg: shared types and constants of the text run finder
// Run modes, configuration bundle, result item and buffer handshake types.
// ----------------------------------------------------------------------------
package trf_pkg;

  localparam int unsigned PosW     = 32;
  localparam int unsigned LenW     = 17;
  localparam int unsigned RegW     = 16;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CharsetN = 256;

  localparam logic [RegW-1:0]     MinLenRst  = 16'd4;
  localparam logic [RegW-1:0]     MaxLenRst  = 16'd1024;
  localparam logic [CfgDataW-1:0] CsWord0Rst = 64'hFFFF_FFFF_0000_0000;
  localparam logic [CfgDataW-1:0] CsWord1Rst = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [CfgDataW-1:0] CsWord2Rst = 64'h0;
  localparam logic [CfgDataW-1:0] CsWord3Rst = 64'h0;

  localparam logic [7:0] PrintLo = 8'h21;
  localparam logic [7:0] PrintHi = 8'h7E;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MIN_LENGTH = 3'd0,
    REG_MAX_LENGTH = 3'd1,
    REG_UNICODE_EN = 3'd2,
    REG_CHARSET_W0 = 3'd3,
    REG_CHARSET_W1 = 3'd4,
    REG_CHARSET_W2 = 3'd5,
    REG_CHARSET_W3 = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FIRST = 2'd1,
    MODE_ASCII = 2'd2,
    MODE_WIDE  = 2'd3
  } run_mode_e;

  typedef struct packed {
    logic [RegW-1:0]     min_length;
    logic [RegW-1:0]     max_length;
    logic                unicode_enable;
    logic [CharsetN-1:0] charset;
  } trf_cfg_t;

  typedef struct packed {
    logic [PosW-1:0] start;
    logic [LenW-1:0] length;
    logic            wide;
    logic            last;
  } trf_res_t;

  // results of one byte towards the output buffer
  typedef struct packed {
    logic     push;
    logic     two;
    trf_res_t r0;
    trf_res_t r1;
  } trf_push_t;

  // run is reportable when its character count exceeds the minimum
  function automatic logic trf_long_enough(logic [LenW-1:0] len, logic wide,
                                           logic [RegW-1:0] min_len);
    logic [LenW-1:0] chars;
    chars = wide ? (len >> 1) : len;
    return chars > {1'b0, min_len};
  endfunction

endpackage

// ----- rtl/trf_cfg_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_cfg_regs: configuration register file
// Decodes writes into length limits, unicode enable and the charset bitmap.
// ----------------------------------------------------------------------------
module trf_cfg_regs
  import trf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output trf_cfg_t            cfg_o
);

  logic [RegW-1:0]     min_q, min_d;
  logic [RegW-1:0]     max_q, max_d;
  logic                uni_q, uni_d;
  logic [CfgDataW-1:0] w0_q, w0_d, w1_q, w1_d, w2_q, w2_d, w3_q, w3_d;

  always_comb begin
    min_d = min_q;
    max_d = max_q;
    uni_d = uni_q;
    w0_d  = w0_q;
    w1_d  = w1_q;
    w2_d  = w2_q;
    w3_d  = w3_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_MIN_LENGTH: min_d = cfg_data_i[RegW-1:0];
        REG_MAX_LENGTH: max_d = cfg_data_i[RegW-1:0];
        REG_UNICODE_EN: uni_d = cfg_data_i[0];
        REG_CHARSET_W0: w0_d  = cfg_data_i;
        REG_CHARSET_W1: w1_d  = cfg_data_i;
        REG_CHARSET_W2: w2_d  = cfg_data_i;
        REG_CHARSET_W3: w3_d  = cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MinLenRst;
      max_q <= MaxLenRst;
      uni_q <= 1'b1;
      w0_q  <= CsWord0Rst;
      w1_q  <= CsWord1Rst;
      w2_q  <= CsWord2Rst;
      w3_q  <= CsWord3Rst;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
      uni_q <= uni_d;
      w0_q  <= w0_d;
      w1_q  <= w1_d;
      w2_q  <= w2_d;
      w3_q  <= w3_d;
    end
  end

  assign cfg_o.min_length     = min_q;
  assign cfg_o.max_length     = max_q;
  assign cfg_o.unicode_enable = uni_q;
  assign cfg_o.charset        = {w3_q, w2_q, w1_q, w0_q};

endmodule

// ----- rtl/trf_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_scan: input register and run state machine
// Holds one byte, updates the run state and forms up to two findings.
// ----------------------------------------------------------------------------
module trf_scan
  import trf_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  trf_cfg_t   cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_stream_i,
  input  logic       buf_free_i,
  output trf_push_t  push_o
);

  logic            vld_q, vld_d;
  logic [7:0]      byte_q;
  logic            eos_q;
  run_mode_e       mode_q, mode_d;
  logic            pend_q, pend_d;
  logic [LenW-1:0] len_q, len_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic            advance, accept;

  // first finding (run ended by this byte) and flush finding (end of stream)
  logic            a_hit, a_wide, a_ok, b_ok, b_wide;
  logic [LenW-1:0] a_len;
  logic            allowed, restart;
  trf_res_t        res_a, res_b;

  assign advance    = vld_q && buf_free_i;
  assign in_ready_o = !vld_q || advance;
  assign accept     = in_valid_i && in_ready_o;
  assign allowed    = cfg_i.charset[byte_q];

  always_comb begin
    mode_d  = mode_q;
    pend_d  = pend_q;
    len_d   = len_q;
    start_d = start_q;
    pos_d   = pos_q;
    a_hit   = 1'b0;
    a_wide  = 1'b0;
    a_len   = len_q;
    restart = 1'b0;
    b_ok    = 1'b0;

    unique case (mode_q)
      MODE_FIRST: begin
        if (byte_q == 8'h00) begin
          if (cfg_i.unicode_enable) begin
            mode_d = MODE_WIDE;
            pend_d = 1'b0;
            len_d  = LenW'(2);
            if (len_d >= {1'b0, cfg_i.max_length}) begin
              a_hit  = 1'b1;
              a_wide = 1'b1;
              a_len  = len_d;
              mode_d = MODE_IDLE;
            end
          end else begin
            mode_d = MODE_IDLE;
          end
        end else begin
          mode_d = MODE_ASCII;
          if (len_q >= {1'b0, cfg_i.max_length}) begin
            // single-byte run already at the cut length
            a_hit   = 1'b1;
            restart = 1'b1;
          end else if (allowed) begin
            len_d = len_q + LenW'(1);
            if (len_d >= {1'b0, cfg_i.max_length}) begin
              a_hit  = 1'b1;
              a_len  = len_d;
              mode_d = MODE_IDLE;
            end
          end else begin
            a_hit   = 1'b1;
            restart = 1'b1;
          end
        end
      end
      MODE_ASCII: begin
        if (allowed) begin
          len_d = len_q + LenW'(1);
          if (len_d >= {1'b0, cfg_i.max_length}) begin
            a_hit  = 1'b1;
            a_len  = len_d;
            mode_d = MODE_IDLE;
          end
        end else begin
          a_hit   = 1'b1;
          restart = 1'b1;
        end
      end
      MODE_WIDE: begin
        a_wide = 1'b1;
        if (!pend_q) begin
          if (allowed) begin
            pend_d = 1'b1;
          end else begin
            a_hit   = 1'b1;
            restart = 1'b1;
          end
        end else if (byte_q == 8'h00) begin
          pend_d = 1'b0;
          len_d  = len_q + LenW'(2);
          if (len_d >= {1'b0, cfg_i.max_length}) begin
            a_hit  = 1'b1;
            a_len  = len_d;
            mode_d = MODE_IDLE;
            pend_d = 1'b0;
          end
        end else begin
          // held char never got its zero byte: dropped from the run
          a_hit   = 1'b1;
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    if (restart) begin
      mode_d = MODE_IDLE;
      pend_d = 1'b0;
      if (byte_q >= PrintLo && byte_q <= PrintHi && allowed) begin
        mode_d  = MODE_FIRST;
        start_d = pos_q;
        len_d   = LenW'(1);
      end
    end

    pos_d  = pos_q + PosW'(1);
    // kind of the run still open after this byte
    b_wide = (mode_d == MODE_WIDE);

    if (eos_q) begin
      b_ok   = (mode_d != MODE_IDLE) &&
               trf_long_enough(len_d, b_wide, cfg_i.min_length);
      mode_d = MODE_IDLE;
      pend_d = 1'b0;
      pos_d  = '0;
    end
  end

  assign a_ok = a_hit && trf_long_enough(a_len, a_wide, cfg_i.min_length);

  always_comb begin
    res_a.start  = start_q;
    res_a.length = a_len;
    res_a.wide   = a_wide;
    res_a.last   = !b_ok;
    res_b.start  = start_d;
    res_b.length = len_d;
    res_b.wide   = b_wide;
    res_b.last   = 1'b1;
    push_o.push  = advance && (a_ok || b_ok);
    push_o.two   = a_ok && b_ok;
    push_o.r0    = a_ok ? res_a : res_b;
    push_o.r1    = res_b;
  end

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (advance) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      eos_q  <= end_of_stream_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      mode_q  <= MODE_IDLE;
      pend_q  <= 1'b0;
      len_q   <= '0;
      start_q <= '0;
      pos_q   <= '0;
    end else begin
      vld_q <= vld_d;
      if (advance) begin
        mode_q  <= mode_d;
        pend_q  <= pend_d;
        len_q   <= len_d;
        start_q <= start_d;
        pos_q   <= pos_d;
      end
    end
  end

endmodule

// ----- rtl/trf_out_buf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_out_buf: two-entry result buffer
// Takes up to two findings per byte and hands them out one item per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module trf_out_buf
  import trf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  trf_push_t push_i,
  output logic      buf_free_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output trf_res_t  res_o
);

  trf_res_t   s0_q, s0_d, s1_q, s1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  // a new byte may only land when the buffer is empty or its single item leaves this cycle
  assign buf_free_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);
  assign res_o       = s0_q;

  always_comb begin
    s0_d  = s0_q;
    s1_d  = s1_q;
    cnt_d = cnt_q;
    if (push_i.push) begin
      s0_d  = push_i.r0;
      s1_d  = push_i.r1;
      cnt_d = push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      s0_d  = s1_q;
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

// ----- rtl/text_run_finder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_run_finder: printable ASCII / UTF-16LE run finder
// A closing byte is registered in the input register, its finding in the
// result buffer. Throughput: one byte per cycle while results are taken; a
// byte with two findings holds the input while the two-entry buffer drains.
// Reset: async active low; registers return to defaults, position and run
// state clear to zero / idle, no clearing pass.
// ----------------------------------------------------------------------------
module text_run_finder
  import trf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                end_of_stream_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PosW-1:0]     found_start_o,
  output logic [LenW-1:0]     found_length_o,
  output logic                is_wide_o,
  output logic                last_result_o
);

  trf_cfg_t  cfg;
  trf_push_t push;
  trf_res_t  res;
  logic      buf_free;

  trf_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  trf_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .buf_free_i      (buf_free),
    .push_o          (push)
  );

  trf_out_buf u_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .buf_free_o  (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  assign found_start_o  = res.start;
  assign found_length_o = res.length;
  assign is_wide_o      = res.wide;
  assign last_result_o  = res.last;

endmodule

// ----- rtl/trf_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trf_checker: port-level checks for the text run finder
// Item hold under stall on both sides and consistency of reported run lengths.
// ----------------------------------------------------------------------------
module trf_checker
  import trf_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic [7:0]          data_byte_i,
  input logic                end_of_stream_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [PosW-1:0]     found_start_o,
  input logic [LenW-1:0]     found_length_o,
  input logic                is_wide_o,
  input logic                last_result_o
);

  // waiting input item holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(data_byte_i) &&
    $stable(end_of_stream_i))
    else $error("input item changed while stalled");

  // stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(found_start_o) &&
    $stable(found_length_o) && $stable(is_wide_o) && $stable(last_result_o))
    else $error("result item changed while stalled");

  a_len_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> found_length_o != '0)
    else $error("zero-length finding");

  // wide runs are whole char/zero pairs
  a_wide_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_wide_o |-> !found_length_o[0])
    else $error("odd-length wide finding");

  // a finding that is not the last of its byte is followed by its partner
  a_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_result_o |=> out_valid_o)
    else $error("second finding of a byte missing");

endmodule

bind text_run_finder trf_checker u_trf_checker (.*);
